// ===== rtl/slla_pkg.sv =====
// Shared types and constants for the sparse linear layer.
// No dependencies; every other file refers to it by scoped names.
package slla_pkg;

	typedef enum logic [1:0] {
		CMD_WEIGHT  = 2'd0,
		CMD_BIAS    = 2'd1,
		CMD_NONZERO = 2'd2,
		CMD_END     = 2'd3
	} cmd_t;

	// one classified item as it waits in the queue
	typedef struct packed {
		cmd_t        cmd;
		logic [3:0]  out_idx;
		logic [7:0]  in_idx;
		logic [31:0] value;
		logic        idx_ok;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic emitting;
	} back_stat_t;

	localparam int QDEPTH = 4;
	localparam logic [31:0] QNAN = 32'h7FC0_0000;

endpackage

// ===== rtl/sparse_linear_layer.sv =====
// Top level of the sparse linear layer: front end, item queue and back end.
// Uses slla_pkg, slla_front, slla_queue and slla_back.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | command, out_index, in_index, value
//  out     | out_valid / out_stall| result_index, activation, last
//
// A weight or bias write is done as the item is popped. A nonzero uses one
// fp32 multiply and add, shared by all outputs, and each output walks read,
// normalize, multiply, round, align and round stages. End of row walks read,
// load and wait states per output; wait holds while out_stall is high. The
// four-entry queue takes items until full while the back end works or stalls.
// arst_n clears control state; weight and bias memories hold no reset value.
module sparse_linear_layer #(
	parameter int OUT_DIM = 16,
	parameter int IN_DIM  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [3:0]  out_index,
	input  logic [7:0]  in_index,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  result_index,
	output logic [31:0] activation,
	output logic        last
);

	logic                 push, q_full, pop, head_valid;
	slla_pkg::entry_t     push_entry, head;
	slla_pkg::back_stat_t stat;

	slla_front #(.OUT_DIM(OUT_DIM), .IN_DIM(IN_DIM)) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.out_index  (out_index),
		.in_index   (in_index),
		.value      (value),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	slla_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	slla_back #(.OUT_DIM(OUT_DIM), .IN_DIM(IN_DIM)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_index (result_index),
		.activation   (activation),
		.last         (last),
		.stat         (stat)
	);

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stat.emitting)
		else $error("result shown outside emit state");

	a_last_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> (!out_valid && !stat.busy))
		else $error("back end not idle after last result");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (result_index == 4'(OUT_DIM - 1)))
		else $error("last flag on wrong output");

	a_gap_between: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> (!out_valid && stat.busy))
		else $error("row emission dropped early");

endmodule

// ===== rtl/slla_front.sv =====
// Front end: takes input items and checks their indexes against the layer size.
// Uses slla_pkg; feeds slla_queue.
module slla_front #(
	parameter int OUT_DIM = 16,
	parameter int IN_DIM  = 256
) (
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            command,
	input  logic [3:0]            out_index,
	input  logic [7:0]            in_index,
	input  logic [31:0]           value,
	output logic                  push,
	output slla_pkg::entry_t      push_entry,
	input  logic                  q_full
);

	logic out_ok;
	logic in_ok;

	assign out_ok = ({28'd0, out_index} < 32'(OUT_DIM));
	assign in_ok  = ({24'd0, in_index} < 32'(IN_DIM));

	always_comb begin
		push_entry.cmd     = slla_pkg::cmd_t'(command);
		push_entry.out_idx = out_index;
		push_entry.in_idx  = in_index;
		push_entry.value   = value;
		unique case (slla_pkg::cmd_t'(command))
			slla_pkg::CMD_WEIGHT:  push_entry.idx_ok = out_ok & in_ok;
			slla_pkg::CMD_BIAS:    push_entry.idx_ok = out_ok;
			slla_pkg::CMD_NONZERO: push_entry.idx_ok = in_ok;
			slla_pkg::CMD_END:     push_entry.idx_ok = 1'b1;
			default:               push_entry.idx_ok = 1'b0;
		endcase
	end

	assign in_stall = q_full;
	assign push     = in_valid & ~q_full;

endmodule

// ===== rtl/slla_queue.sv =====
// Short item queue between the front end and the back end.
// Uses slla_pkg for the entry type and depth.
module slla_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  slla_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output slla_pkg::entry_t head
);

	localparam int PW = $clog2(slla_pkg::QDEPTH);

	slla_pkg::entry_t slot_q [slla_pkg::QDEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      cnt_q;

	assign full       = (cnt_q == (PW+1)'(slla_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (PW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/slla_back.sv =====
// Back end: weight, bias and accumulator memories, one shared fp32 multiply/add,
// and the sequencer that updates and emits the accumulators. Uses slla_pkg.
module slla_back #(
	parameter int OUT_DIM = 16,
	parameter int IN_DIM  = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  slla_pkg::entry_t     head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           result_index,
	output logic [31:0]          activation,
	output logic                 last,
	output slla_pkg::back_stat_t stat
);

	localparam int NW     = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
	localparam int WDEPTH = OUT_DIM * IN_DIM;
	localparam int WA     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam logic [WA-1:0] ROW_STEP = WA'(IN_DIM);
	localparam logic [NW-1:0] N_LAST   = NW'(OUT_DIM - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_NZ_RD, ST_NZ_OPN, ST_NZ_MUL, ST_NZ_RND, ST_NZ_ADD1, ST_NZ_ADD2,
		ST_EO_RD, ST_EO_LOAD, ST_EO_WAIT
	} state_t;

	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] c;
		logic       found;
		c     = 5'd0;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found) begin
				if (v[i])
					found = 1'b1;
				else
					c = c + 5'd1;
			end
		end
		return c;
	endfunction

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] c;
		logic       found;
		c     = 5'd0;
		found = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!found) begin
				if (v[i])
					found = 1'b1;
				else
					c = c + 5'd1;
			end
		end
		return c;
	endfunction

	// sig has its leading one at bit 26, low three bits are guard/round/sticky;
	// value = sig/2^26 * 2^(be-127). Round to nearest even, subnormals and overflow.
	function automatic logic [31:0] fp_pack(input logic s, input logic signed [10:0] be,
			input logic [26:0] sig);
		logic signed [10:0] shamt;
		logic signed [10:0] e2;
		logic [26:0]        sh;
		logic [26:0]        mask;
		logic [24:0]        m;
		logic [22:0]        mant;
		logic               inc;
		logic [31:0]        r;
		shamt = 11'sd1 - be;
		mask  = '0;
		if (be > 11'sd0) begin
			sh = sig;
			e2 = be;
		end else if (shamt > 11'sd26) begin
			sh = {26'd0, |sig};
			e2 = 11'sd0;
		end else begin
			mask  = (27'd1 << shamt[4:0]) - 27'd1;
			sh    = sig >> shamt[4:0];
			sh[0] = sh[0] | (|(sig & mask));
			e2    = 11'sd0;
		end
		inc = sh[2] & (sh[1] | sh[0] | sh[3]);
		m   = {1'b0, sh[26:3]} + 25'(inc);
		if (e2 == 11'sd0) begin
			r = {s, 7'd0, m[23], m[22:0]};
		end else begin
			if (m[24]) begin
				e2   = e2 + 11'sd1;
				mant = m[23:1];
			end else begin
				mant = m[22:0];
			end
			if (e2 >= 11'sd255)
				r = {s, 8'hFF, 23'd0};
			else
				r = {s, e2[7:0], mant};
		end
		return r;
	endfunction

	function automatic logic [31:0] canon(input logic [31:0] b);
		if (b[30:23] == 8'hFF && b[22:0] != 23'd0)
			return slla_pkg::QNAN;
		return b;
	endfunction

	// ---------------- storage ----------------
	logic [31:0]   weight_mem [WDEPTH];
	logic [31:0]   bias_mem   [OUT_DIM];
	logic [31:0]   acc_mem    [OUT_DIM];
	logic [31:0]   w_rd_q, b_rd_q, a_rd_q;

	state_t        state_q;
	logic [NW-1:0] n_q;
	logic [WA-1:0] base_q;
	logic          row_open_q;
	logic [7:0]    col_q;
	logic [31:0]   x_q;
	logic          col_ok_q;
	logic          out_valid_q;
	logic [3:0]    result_index_q;
	logic [31:0]   activation_q;
	logic          last_q;

	logic          w_we, b_we, acc_we;
	logic [WA-1:0] w_waddr, w_raddr;
	logic [31:0]   acc_wdata;

	assign pop     = (state_q == ST_IDLE) && head_valid;
	assign w_we    = pop && (head.cmd == slla_pkg::CMD_WEIGHT) && head.idx_ok;
	assign b_we    = pop && (head.cmd == slla_pkg::CMD_BIAS) && head.idx_ok;
	assign acc_we  = (state_q == ST_NZ_ADD2);
	assign w_waddr = WA'(head.out_idx) * ROW_STEP + WA'(head.in_idx);
	assign w_raddr = base_q + WA'(col_q);

	always_ff @(posedge clk) begin
		if (w_we)
			weight_mem[w_waddr] <= head.value;
		w_rd_q <= weight_mem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (b_we)
			bias_mem[NW'(head.out_idx)] <= head.value;
		b_rd_q <= bias_mem[n_q];
	end

	always_ff @(posedge clk) begin
		if (acc_we)
			acc_mem[n_q] <= acc_wdata;
		a_rd_q <= acc_mem[n_q];
	end

	// ---------------- fp datapath ----------------
	// operand check and normalize
	logic               spec_c, sgn_c;
	logic [31:0]        specv_c, addend_c;
	logic [23:0]        mw_c, mx_c;
	logic [4:0]         lzw_c, lzx_c;
	logic signed [10:0] ew_c, ex_c;
	logic               w_nan, x_nan, w_inf, x_inf, w_zero, x_zero;

	logic               spec_s1, sgn_s1;
	logic [31:0]        specv_s1, addend_s1;
	logic [23:0]        ma_s1, mb_s1;
	logic signed [10:0] ea_s1, eb_s1;
	logic [47:0]        prod_s2;
	logic signed [10:0] esum_s2;
	logic [31:0]        pm_s3;
	logic [27:0]        sum_s4;
	logic signed [10:0] ebig_s4;
	logic               sgn_s4, zs_s4, aspec_s4;
	logic [31:0]        aspecv_s4;

	always_comb begin
		w_nan  = (w_rd_q[30:23] == 8'hFF) && (w_rd_q[22:0] != 23'd0);
		x_nan  = (x_q[30:23] == 8'hFF) && (x_q[22:0] != 23'd0);
		w_inf  = (w_rd_q[30:23] == 8'hFF) && (w_rd_q[22:0] == 23'd0);
		x_inf  = (x_q[30:23] == 8'hFF) && (x_q[22:0] == 23'd0);
		w_zero = (w_rd_q[30:0] == 31'd0);
		x_zero = (x_q[30:0] == 31'd0);
		sgn_c  = w_rd_q[31] ^ x_q[31];
		spec_c = 1'b1;
		if (w_nan || x_nan || (w_inf && x_zero) || (x_inf && w_zero))
			specv_c = slla_pkg::QNAN;
		else if (w_inf || x_inf)
			specv_c = {sgn_c, 8'hFF, 23'd0};
		else if (w_zero || x_zero)
			specv_c = {sgn_c, 31'd0};
		else begin
			specv_c = '0;
			spec_c  = 1'b0;
		end
		mw_c  = {|w_rd_q[30:23], w_rd_q[22:0]};
		mx_c  = {|x_q[30:23], x_q[22:0]};
		lzw_c = lzc24(mw_c);
		lzx_c = lzc24(mx_c);
		ew_c  = ((w_rd_q[30:23] == 8'd0) ? 11'sd1 : signed'({3'd0, w_rd_q[30:23]}))
			- signed'({6'd0, lzw_c});
		ex_c  = ((x_q[30:23] == 8'd0) ? 11'sd1 : signed'({3'd0, x_q[30:23]}))
			- signed'({6'd0, lzx_c});
		addend_c = row_open_q ? a_rd_q : b_rd_q;
	end

	// product rounding
	logic [26:0]        psig_c;
	logic signed [10:0] pbe_c;
	always_comb begin
		if (prod_s2[47]) begin
			psig_c = {prod_s2[47:22], |prod_s2[21:0]};
			pbe_c  = esum_s2 - 11'sd126;
		end else begin
			psig_c = {prod_s2[46:21], |prod_s2[20:0]};
			pbe_c  = esum_s2 - 11'sd127;
		end
	end

	// add: align and sum
	logic        a_nan, b_nan, a_inf, b_inf, a_big;
	logic [31:0] big_c, sml_c;
	logic [7:0]  ebig_c, esml_c, d_c;
	logic [26:0] mbig_c, msml_c, msh_c, dmask_c;
	logic [27:0] sum_c;
	always_comb begin
		a_nan = (addend_s1[30:23] == 8'hFF) && (addend_s1[22:0] != 23'd0);
		b_nan = (pm_s3[30:23] == 8'hFF) && (pm_s3[22:0] != 23'd0);
		a_inf = (addend_s1[30:23] == 8'hFF) && (addend_s1[22:0] == 23'd0);
		b_inf = (pm_s3[30:23] == 8'hFF) && (pm_s3[22:0] == 23'd0);
		a_big = (addend_s1[30:0] >= pm_s3[30:0]);
		big_c = a_big ? addend_s1 : pm_s3;
		sml_c = a_big ? pm_s3 : addend_s1;
		ebig_c  = (big_c[30:23] == 8'd0) ? 8'd1 : big_c[30:23];
		esml_c  = (sml_c[30:23] == 8'd0) ? 8'd1 : sml_c[30:23];
		d_c     = ebig_c - esml_c;
		mbig_c  = {|big_c[30:23], big_c[22:0], 3'd0};
		msml_c  = {|sml_c[30:23], sml_c[22:0], 3'd0};
		dmask_c = '0;
		if (d_c > 8'd26) begin
			msh_c = {26'd0, |msml_c};
		end else begin
			dmask_c  = (27'd1 << d_c[4:0]) - 27'd1;
			msh_c    = msml_c >> d_c[4:0];
			msh_c[0] = msh_c[0] | (|(msml_c & dmask_c));
		end
		if (big_c[31] != sml_c[31])
			sum_c = {1'b0, mbig_c} - {1'b0, msh_c};
		else
			sum_c = {1'b0, mbig_c} + {1'b0, msh_c};
	end

	// add: normalize and round
	logic [4:0]         lzs_c;
	logic [26:0]        ssig_c;
	logic signed [10:0] sbe_c;
	logic [31:0]        add_res_c;
	always_comb begin
		lzs_c = lzc27(sum_s4[26:0]);
		if (sum_s4[27]) begin
			ssig_c = {sum_s4[27:2], sum_s4[1] | sum_s4[0]};
			sbe_c  = ebig_s4 + 11'sd1;
		end else begin
			ssig_c = sum_s4[26:0] << lzs_c;
			sbe_c  = ebig_s4 - signed'({6'd0, lzs_c});
		end
		if (aspec_s4)
			add_res_c = aspecv_s4;
		else if (sum_s4 == 28'd0)
			add_res_c = {zs_s4, 31'd0};
		else
			add_res_c = fp_pack(sgn_s4, sbe_c, ssig_c);
		acc_wdata = col_ok_q ? add_res_c : addend_s1;
	end

	// stage registers load every cycle; the sequencer only looks at them in order
	always_ff @(posedge clk) begin
		spec_s1   <= spec_c;
		specv_s1  <= specv_c;
		sgn_s1    <= sgn_c;
		ma_s1     <= mw_c << lzw_c;
		mb_s1     <= mx_c << lzx_c;
		ea_s1     <= ew_c;
		eb_s1     <= ex_c;
		addend_s1 <= addend_c;
		prod_s2   <= ma_s1 * mb_s1;
		esum_s2   <= ea_s1 + eb_s1;
		pm_s3     <= spec_s1 ? specv_s1 : fp_pack(sgn_s1, pbe_c, psig_c);
		sum_s4    <= sum_c;
		ebig_s4   <= signed'({3'd0, ebig_c});
		sgn_s4    <= big_c[31];
		zs_s4     <= (addend_s1[31] == pm_s3[31]) ? addend_s1[31] : 1'b0;
		aspec_s4  <= a_nan | b_nan | a_inf | b_inf;
		if (a_nan || b_nan || (a_inf && b_inf && (addend_s1[31] != pm_s3[31])))
			aspecv_s4 <= slla_pkg::QNAN;
		else if (a_inf)
			aspecv_s4 <= addend_s1;
		else
			aspecv_s4 <= pm_s3;
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			n_q            <= '0;
			base_q         <= '0;
			row_open_q     <= 1'b0;
			col_q          <= '0;
			x_q            <= '0;
			col_ok_q       <= 1'b0;
			out_valid_q    <= 1'b0;
			result_index_q <= '0;
			activation_q   <= '0;
			last_q         <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						col_q    <= head.in_idx;
						x_q      <= head.value;
						col_ok_q <= head.idx_ok;
						n_q      <= '0;
						base_q   <= '0;
						unique case (head.cmd)
							slla_pkg::CMD_NONZERO:               state_q <= ST_NZ_RD;
							slla_pkg::CMD_END:                   state_q <= ST_EO_RD;
							slla_pkg::CMD_WEIGHT, slla_pkg::CMD_BIAS: state_q <= ST_IDLE;
							default:                             state_q <= ST_IDLE;
						endcase
					end
				end
				ST_NZ_RD:   state_q <= ST_NZ_OPN;
				ST_NZ_OPN:  state_q <= ST_NZ_MUL;
				ST_NZ_MUL:  state_q <= ST_NZ_RND;
				ST_NZ_RND:  state_q <= ST_NZ_ADD1;
				ST_NZ_ADD1: state_q <= ST_NZ_ADD2;
				ST_NZ_ADD2: begin
					if (n_q == N_LAST) begin
						row_open_q <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						n_q     <= n_q + NW'(1);
						base_q  <= base_q + ROW_STEP;
						state_q <= ST_NZ_RD;
					end
				end
				ST_EO_RD:   state_q <= ST_EO_LOAD;
				ST_EO_LOAD: begin
					activation_q   <= canon(row_open_q ? a_rd_q : b_rd_q);
					result_index_q <= 4'(n_q);
					last_q         <= (n_q == N_LAST);
					out_valid_q    <= 1'b1;
					state_q        <= ST_EO_WAIT;
				end
				ST_EO_WAIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							row_open_q <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							n_q     <= n_q + NW'(1);
							state_q <= ST_EO_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result_index  = result_index_q;
	assign activation    = activation_q;
	assign last          = last_q;
	assign stat.busy     = (state_q != ST_IDLE);
	assign stat.emitting = (state_q == ST_EO_WAIT);

endmodule
